// ===== rtl/core/ssp_pkg.sv =====
package ssp_pkg;

  localparam int SCREEN_W_DEF = 640;
  localparam int SCREEN_H_DEF = 480;
  localparam int LIFT_ROWS    = 20;
  localparam int FRAC_BITS    = 16;
  localparam int WORD_W       = 32;
  localparam int CFG_IDX_W    = 3;

  localparam logic signed [WORD_W-1:0] PLAYER_X_RST = 32'sd0;
  localparam logic signed [WORD_W-1:0] PLAYER_Y_RST = 32'sd0;
  localparam logic signed [WORD_W-1:0] DIR_X_RST    = 32'sd65536;
  localparam logic signed [WORD_W-1:0] DIR_Y_RST    = 32'sd0;
  localparam logic signed [WORD_W-1:0] PLANE_X_RST  = 32'sd0;
  localparam logic signed [WORD_W-1:0] PLANE_Y_RST  = 32'sd43254;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLAYER_X = 3'd0,
    REG_PLAYER_Y = 3'd1,
    REG_DIR_X    = 3'd2,
    REG_DIR_Y    = 3'd3,
    REG_PLANE_X  = 3'd4,
    REG_PLANE_Y  = 3'd5
  } reg_idx_t;

  // sideband through the camera-space divider
  typedef struct packed {
    logic lift;
    logic half;
    logic dzero;
    logic ovf_x;
    logic ovf_y;
    logic neg_x;
    logic neg_y;
  } tag1_t;

  // sideband through the screen-space divider
  typedef struct packed {
    logic signed [WORD_W-1:0] ty;
    logic                     inv;
    logic                     lift;
    logic                     half;
    logic                     sx_neg;
  } tag2_t;

  // signed Q16.16 from sign, overflow and magnitude quotient, saturated
  function automatic logic signed [WORD_W-1:0] sat_q16(input logic neg, input logic ovf,
                                                       input logic [WORD_W-1:0] q);
    logic signed [WORD_W-1:0] res;
    if (neg) begin
      if (ovf || q > 32'h8000_0000) begin
        res = 32'sh8000_0000;
      end else begin
        res = $signed(32'(-q));
      end
    end else begin
      if (ovf || q[WORD_W-1]) begin
        res = 32'sh7FFF_FFFF;
      end else begin
        res = $signed(q);
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/ssp_div.sv =====
module ssp_div #(
  parameter int NW = 80,
  parameter int DW = 64,
  parameter int QW = 32,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          vld_in,
  input  logic [TW-1:0] tag_in,
  input  logic [NW-1:0] num_a,
  input  logic [NW-1:0] num_b,
  input  logic [DW-1:0] den,
  output logic          vld_out,
  output logic [TW-1:0] tag_out,
  output logic [QW-1:0] quo_a,
  output logic [QW-1:0] quo_b
);

  // one quotient bit per stage; numerators share the divisor
  logic          r_vld   [1:QW];
  logic [TW-1:0] r_tag   [1:QW];
  logic [DW-1:0] r_den   [1:QW];
  logic [DW-1:0] r_rem_a [1:QW];
  logic [DW-1:0] r_rem_b [1:QW];
  logic [QW-1:0] r_sh_a  [1:QW];
  logic [QW-1:0] r_sh_b  [1:QW];

  logic          c_vld   [0:QW-1];
  logic [TW-1:0] c_tag   [0:QW-1];
  logic [DW-1:0] c_den   [0:QW-1];
  logic [DW-1:0] c_rem_a [0:QW-1];
  logic [DW-1:0] c_rem_b [0:QW-1];
  logic [QW-1:0] c_sh_a  [0:QW-1];
  logic [QW-1:0] c_sh_b  [0:QW-1];
  logic [DW:0]   n_a     [0:QW-1];
  logic [DW:0]   n_b     [0:QW-1];

  function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic in_bit,
                                           input logic [DW-1:0] d);
    logic [DW:0] rr;
    logic [DW:0] res;
    rr = {rem, in_bit};
    if (rr >= {1'b0, d}) begin
      res = {1'b1, DW'(rr - {1'b0, d})};
    end else begin
      res = {1'b0, rr[DW-1:0]};
    end
    return res;
  endfunction

  always_comb begin
    c_vld[0]   = vld_in;
    c_tag[0]   = tag_in;
    c_den[0]   = den;
    c_rem_a[0] = DW'(num_a >> QW);
    c_rem_b[0] = DW'(num_b >> QW);
    c_sh_a[0]  = num_a[QW-1:0];
    c_sh_b[0]  = num_b[QW-1:0];
    for (int k = 1; k < QW; k++) begin
      c_vld[k]   = r_vld[k];
      c_tag[k]   = r_tag[k];
      c_den[k]   = r_den[k];
      c_rem_a[k] = r_rem_a[k];
      c_rem_b[k] = r_rem_b[k];
      c_sh_a[k]  = r_sh_a[k];
      c_sh_b[k]  = r_sh_b[k];
    end
    for (int k = 0; k < QW; k++) begin
      n_a[k] = div_step(c_rem_a[k], c_sh_a[k][QW-1], c_den[k]);
      n_b[k] = div_step(c_rem_b[k], c_sh_b[k][QW-1], c_den[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (rst) begin
        r_vld[k+1] <= 1'b0;
      end else begin
        r_vld[k+1] <= c_vld[k];
      end
      r_tag[k+1]   <= c_tag[k];
      r_den[k+1]   <= c_den[k];
      r_rem_a[k+1] <= n_a[k][DW-1:0];
      r_rem_b[k+1] <= n_b[k][DW-1:0];
      // shift the dividend out and the quotient bit in
      r_sh_a[k+1]  <= {c_sh_a[k][QW-2:0], n_a[k][DW]};
      r_sh_b[k+1]  <= {c_sh_b[k][QW-2:0], n_b[k][DW]};
    end
  end

  assign vld_out = r_vld[QW];
  assign tag_out = r_tag[QW];
  assign quo_a   = r_sh_a[QW];
  assign quo_b   = r_sh_b[QW];

endmodule

// ===== rtl/core/sprite_screen_projection.sv =====
// Sprite screen projection.
// Configuration: write player position, view direction and camera plane
// (signed Q16.16) through cfg_valid/cfg_ready with cfg_index and cfg_data,
// only while no sprite is in flight.
// Input: a sprite transaction is taken at each rising edge with start high
// and busy low; busy is low except right after reset, so one sprite can
// enter in every cycle.
// Output: done pulses for one cycle with depth, screen centre, height,
// draw bounds and depth_invalid. The receiver cannot hold results off.
// Pipeline: two bit-serial division pipelines, 32 stages for the
// camera-space transform and SNW stages for the screen centre and
// height, where SNW is the width of the centre-column quotient (41 at
// 640 columns).
// Throughput: one sprite per cycle once busy is low.
// Reset: synchronous; clears the configuration to its defaults and drops
// every sprite in flight.
module sprite_screen_projection #(
  parameter int SCREEN_W = ssp_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = ssp_pkg::SCREEN_H_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ssp_pkg::WORD_W-1:0]   sprite_x,
  input  logic signed [ssp_pkg::WORD_W-1:0]   sprite_y,
  input  logic                                lift_flag,
  input  logic                                half_flag,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssp_pkg::WORD_W-1:0]          cfg_data,
  output logic                                done,
  output logic signed [ssp_pkg::WORD_W-1:0]   depth,
  output logic signed [15:0]                  screen_center_x,
  output logic [15:0]                         proj_height,
  output logic [8:0]                          top_row,
  output logic [8:0]                          bottom_row,
  output logic [9:0]                          draw_start_x,
  output logic [9:0]                          draw_end_x,
  output logic                                depth_invalid
);

  localparam int HALF_W  = SCREEN_W / 2;
  localparam int SNW     = $clog2(HALF_W + 1) + 32;
  localparam int SW      = SNW + 2;
  localparam int H_NUM   = SCREEN_H * 65536;
  localparam int LATENCY = 43 + SNW;
  localparam int T1W     = $bits(ssp_pkg::tag1_t);
  localparam int T2W     = $bits(ssp_pkg::tag2_t);

  localparam logic signed [SW-1:0] Y_MAX  = SW'(SCREEN_H - 1);
  localparam logic signed [SW-1:0] X_MAX  = SW'(SCREEN_W - 1);
  localparam logic signed [SW-1:0] Y_MID  = SW'(SCREEN_H / 2);
  localparam logic signed [SW-1:0] LIFT_S = SW'(ssp_pkg::LIFT_ROWS);
  localparam logic signed [SW-1:0] CX_MIN = SW'(-32768);
  localparam logic signed [SW-1:0] CX_MAX = SW'(32767);

  logic signed [31:0] player_x, player_y, view_dir_x, view_dir_y, cam_plane_x, cam_plane_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b1;
      player_x    <= ssp_pkg::PLAYER_X_RST;
      player_y    <= ssp_pkg::PLAYER_Y_RST;
      view_dir_x  <= ssp_pkg::DIR_X_RST;
      view_dir_y  <= ssp_pkg::DIR_Y_RST;
      cam_plane_x <= ssp_pkg::PLANE_X_RST;
      cam_plane_y <= ssp_pkg::PLANE_Y_RST;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ssp_pkg::REG_PLAYER_X: player_x    <= $signed(cfg_data);
          ssp_pkg::REG_PLAYER_Y: player_y    <= $signed(cfg_data);
          ssp_pkg::REG_DIR_X:    view_dir_x  <= $signed(cfg_data);
          ssp_pkg::REG_DIR_Y:    view_dir_y  <= $signed(cfg_data);
          ssp_pkg::REG_PLANE_X:  cam_plane_x <= $signed(cfg_data);
          ssp_pkg::REG_PLANE_Y:  cam_plane_y <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
  end

  assign cfg_ready = !busy;

  // s1: relative position
  logic               s1_vld, s1_lift, s1_half;
  logic signed [32:0] s1_rel_x, s1_rel_y;
  // s2: products
  logic               s2_vld, s2_lift, s2_half;
  logic signed [63:0] s2_det_a, s2_det_b;
  logic signed [64:0] s2_x_a, s2_x_b, s2_y_a, s2_y_b;
  // s3: differences
  logic               s3_vld, s3_lift, s3_half;
  logic signed [64:0] s3_det;
  logic signed [65:0] s3_xn, s3_yn;
  // s4: sign and magnitude
  logic               s4_vld, s4_lift, s4_half, s4_dneg, s4_xneg, s4_yneg;
  logic [63:0]        s4_dmag, s4_xmag, s4_ymag;
  // s5: divider operands
  logic               s5_vld;
  ssp_pkg::tag1_t     s5_tag;
  logic [63:0]        s5_dmag, s5_xmag, s5_ymag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
    end
    s1_rel_x <= 33'(sprite_x) - 33'(player_x);
    s1_rel_y <= 33'(sprite_y) - 33'(player_y);
    s1_lift  <= lift_flag;
    s1_half  <= half_flag;

    s2_det_a <= 64'(cam_plane_x) * 64'(view_dir_y);
    s2_det_b <= 64'(cam_plane_y) * 64'(view_dir_x);
    s2_x_a   <= 65'(view_dir_y) * 65'(s1_rel_x);
    s2_x_b   <= 65'(view_dir_x) * 65'(s1_rel_y);
    s2_y_a   <= 65'(cam_plane_x) * 65'(s1_rel_y);
    s2_y_b   <= 65'(cam_plane_y) * 65'(s1_rel_x);
    s2_lift  <= s1_lift;
    s2_half  <= s1_half;

    s3_det  <= 65'(s2_det_a) - 65'(s2_det_b);
    s3_xn   <= 66'(s2_x_a) - 66'(s2_x_b);
    s3_yn   <= 66'(s2_y_a) - 66'(s2_y_b);
    s3_lift <= s2_lift;
    s3_half <= s2_half;

    s4_dneg <= s3_det[64];
    s4_dmag <= s3_det[64] ? 64'(-s3_det) : 64'(s3_det);
    s4_xneg <= s3_xn[65];
    s4_xmag <= s3_xn[65] ? 64'(-s3_xn) : 64'(s3_xn);
    s4_yneg <= s3_yn[65];
    s4_ymag <= s3_yn[65] ? 64'(-s3_yn) : 64'(s3_yn);
    s4_lift <= s3_lift;
    s4_half <= s3_half;

    // quotient reaches 2^32 when mag >= det << 16
    s5_tag.ovf_x <= {16'h0, s4_xmag} >= {s4_dmag, 16'h0};
    s5_tag.ovf_y <= {16'h0, s4_ymag} >= {s4_dmag, 16'h0};
    s5_tag.dzero <= s4_dmag == 64'd0;
    s5_tag.neg_x <= s4_xneg ^ s4_dneg;
    s5_tag.neg_y <= s4_yneg ^ s4_dneg;
    s5_tag.lift  <= s4_lift;
    s5_tag.half  <= s4_half;
    s5_dmag      <= s4_dmag;
    s5_xmag      <= s4_xmag;
    s5_ymag      <= s4_ymag;
  end

  logic           d1_vld;
  logic [T1W-1:0] d1_tag_raw;
  ssp_pkg::tag1_t d1_tag;
  logic [31:0]    d1_qx, d1_qy;

  ssp_div #(.NW(80), .DW(64), .QW(32), .TW(T1W)) u_div_cam (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (s5_vld),
    .tag_in  (s5_tag),
    .num_a   ({s5_xmag, 16'h0}),
    .num_b   ({s5_ymag, 16'h0}),
    .den     (s5_dmag),
    .vld_out (d1_vld),
    .tag_out (d1_tag_raw),
    .quo_a   (d1_qx),
    .quo_b   (d1_qy)
  );

  assign d1_tag = ssp_pkg::tag1_t'(d1_tag_raw);

  logic                s6_vld, s6_lift, s6_half, s6_dzero;
  logic signed [31:0]  s6_tx, s6_ty;
  logic                s7_vld, s7_lift, s7_half, s7_inv, s7_ty_neg;
  logic signed [32:0]  s7_sum;
  logic signed [31:0]  s7_ty;
  logic [31:0]         s7_ty_abs;
  logic                s8_vld, s8_lift, s8_half, s8_inv, s8_ty_neg;
  logic signed [SNW:0] s8_prod;
  logic signed [31:0]  s8_ty;
  logic [31:0]         s8_ty_abs;
  logic                s9_vld;
  ssp_pkg::tag2_t      s9_tag;
  logic [SNW-1:0]      s9_nmag;
  logic [31:0]         s9_ty_abs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
      s7_vld <= 1'b0;
      s8_vld <= 1'b0;
      s9_vld <= 1'b0;
    end else begin
      s6_vld <= d1_vld;
      s7_vld <= s6_vld;
      s8_vld <= s7_vld;
      s9_vld <= s8_vld;
    end
    s6_tx    <= ssp_pkg::sat_q16(d1_tag.neg_x, d1_tag.ovf_x, d1_qx);
    s6_ty    <= ssp_pkg::sat_q16(d1_tag.neg_y, d1_tag.ovf_y, d1_qy);
    s6_lift  <= d1_tag.lift;
    s6_half  <= d1_tag.half;
    s6_dzero <= d1_tag.dzero;

    s7_sum    <= 33'(s6_tx) + 33'(s6_ty);
    s7_ty     <= s6_ty;
    s7_ty_neg <= s6_ty[31];
    s7_ty_abs <= s6_ty[31] ? 32'(-s6_ty) : 32'(s6_ty);
    s7_inv    <= s6_dzero || (s6_ty == 32'sd0);
    s7_lift   <= s6_lift;
    s7_half   <= s6_half;

    s8_prod   <= (SNW+1)'(s7_sum) * (SNW+1)'(HALF_W);
    s8_ty     <= s7_ty;
    s8_ty_neg <= s7_ty_neg;
    s8_ty_abs <= s7_ty_abs;
    s8_inv    <= s7_inv;
    s8_lift   <= s7_lift;
    s8_half   <= s7_half;

    // truncate toward zero: divide magnitudes, sign applied afterward
    s9_nmag       <= s8_prod[SNW] ? SNW'(-s8_prod) : SNW'(s8_prod);
    s9_tag.sx_neg <= s8_prod[SNW] ^ s8_ty_neg;
    s9_tag.ty     <= s8_ty;
    s9_tag.inv    <= s8_inv;
    s9_tag.lift   <= s8_lift;
    s9_tag.half   <= s8_half;
    s9_ty_abs     <= s8_ty_abs;
  end

  logic           d2_vld;
  logic [T2W-1:0] d2_tag_raw;
  ssp_pkg::tag2_t d2_tag;
  logic [SNW-1:0] d2_qsx, d2_qh;

  ssp_div #(.NW(SNW), .DW(32), .QW(SNW), .TW(T2W)) u_div_scr (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (s9_vld),
    .tag_in  (s9_tag),
    .num_a   (s9_nmag),
    .num_b   (SNW'(H_NUM)),
    .den     (s9_ty_abs),
    .vld_out (d2_vld),
    .tag_out (d2_tag_raw),
    .quo_a   (d2_qsx),
    .quo_b   (d2_qh)
  );

  assign d2_tag = ssp_pkg::tag2_t'(d2_tag_raw);

  logic                s10_vld, s10_lift, s10_inv;
  logic signed [SW-1:0] s10_sx;
  logic [SNW-1:0]      s10_hh, s10_w2;
  logic signed [31:0]  s10_ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_vld <= 1'b0;
    end else begin
      s10_vld <= d2_vld;
    end
    s10_sx   <= d2_tag.sx_neg ? -SW'(d2_qsx) : SW'(d2_qsx);
    s10_w2   <= d2_qh >> 1;
    s10_hh   <= d2_tag.half ? (d2_qh >> 1) : d2_qh;
    s10_ty   <= d2_tag.ty;
    s10_inv  <= d2_tag.inv;
    s10_lift <= d2_tag.lift;
  end

  function automatic logic signed [SW-1:0] clamp(input logic signed [SW-1:0] v,
                                                 input logic signed [SW-1:0] hi);
    logic signed [SW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

  logic signed [SW-1:0] ymid, h2_s, w2_s, hh_s;
  logic signed [SW-1:0] sy0, sy1, sx0, sx1;

  always_comb begin
    ymid = s10_lift ? Y_MID + LIFT_S : Y_MID;
    h2_s = SW'(s10_hh >> 1);
    w2_s = SW'(s10_w2);
    hh_s = SW'(s10_hh);
    sy0  = clamp(ymid - h2_s, Y_MAX);
    sy1  = clamp(ymid + h2_s, Y_MAX);
    sx0  = clamp(s10_sx - w2_s, X_MAX);
    sx1  = clamp(s10_sx + w2_s, X_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s10_vld;
    end
    if (s10_inv) begin
      depth           <= '0;
      screen_center_x <= '0;
      proj_height     <= '0;
      top_row         <= '0;
      bottom_row      <= '0;
      draw_start_x    <= '0;
      draw_end_x      <= '0;
      depth_invalid   <= 1'b1;
    end else begin
      depth <= s10_ty;
      if (s10_sx < CX_MIN) begin
        screen_center_x <= 16'sh8000;
      end else if (s10_sx > CX_MAX) begin
        screen_center_x <= 16'sh7FFF;
      end else begin
        screen_center_x <= 16'(s10_sx);
      end
      proj_height   <= (hh_s > SW'(65535)) ? 16'hFFFF : 16'(s10_hh);
      top_row       <= 9'(sy0);
      bottom_row    <= 9'(sy1);
      draw_start_x  <= 10'(sx0);
      draw_end_x    <= 10'(sx1);
      depth_invalid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/ssp_chk.sv =====
module ssp_chk #(
  parameter int LAT = 84
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] depth,
  input logic [15:0] screen_center_x,
  input logic [15:0] proj_height,
  input logic [8:0]  top_row,
  input logic [8:0]  bottom_row,
  input logic [9:0]  draw_start_x,
  input logic [9:0]  draw_end_x,
  input logic        depth_invalid
);

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && depth_invalid |-> depth == 32'd0 && screen_center_x == 16'd0 &&
      proj_height == 16'd0 && top_row == 9'd0 && bottom_row == 9'd0 &&
      draw_start_x == 10'd0 && draw_end_x == 10'd0)
    else $error("invalid result carries nonzero fields");

  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    done && !depth_invalid |-> top_row <= bottom_row && draw_start_x <= draw_end_x)
    else $error("draw bounds out of order");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a transaction at the pipeline latency");

endmodule

bind sprite_screen_projection ssp_chk #(.LAT(LATENCY)) u_ssp_chk (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .depth           (depth),
  .screen_center_x (screen_center_x),
  .proj_height     (proj_height),
  .top_row         (top_row),
  .bottom_row      (bottom_row),
  .draw_start_x    (draw_start_x),
  .draw_end_x      (draw_end_x),
  .depth_invalid   (depth_invalid)
);

// ===== verif/tb.sv =====
module tb;

  localparam int HALF_W     = ssp_pkg::SCREEN_W_DEF / 2;
  localparam int HALF_H     = ssp_pkg::SCREEN_H_DEF / 2;
  localparam int DRAIN      = 100;
  localparam int MAX_CYCLES = 600000;

  typedef struct {
    logic signed [31:0] depth;
    logic signed [15:0] center;
    logic [15:0]        height;
    logic [8:0]         y0, y1;
    logic [9:0]         x0, x1;
    logic               inv;
  } proj_t;

  class proj_scoreboard;
    logic signed [31:0] px, py, dx, dy, plx, ply;
    proj_t pending[$];
    int errors;

    function new();
      px = ssp_pkg::PLAYER_X_RST; py = ssp_pkg::PLAYER_Y_RST; dx = ssp_pkg::DIR_X_RST;
      dy = ssp_pkg::DIR_Y_RST; plx = ssp_pkg::PLANE_X_RST; ply = ssp_pkg::PLANE_Y_RST;
      errors = 0;
    endfunction

    function void set_reg(ssp_pkg::reg_idx_t idx, logic [31:0] v);
      case (idx)
        ssp_pkg::REG_PLAYER_X: px = v;
        ssp_pkg::REG_PLAYER_Y: py = v;
        ssp_pkg::REG_DIR_X: dx = v;
        ssp_pkg::REG_DIR_Y: dy = v;
        ssp_pkg::REG_PLANE_X: plx = v;
        ssp_pkg::REG_PLANE_Y: ply = v;
        default: ;
      endcase
    endfunction

    // signed Q16.16 quotient, truncated toward zero, saturated
    function longint q16_ratio(logic nneg, logic [65:0] nm, logic dneg, logic [65:0] dm);
      logic [97:0] q;
      logic ovf;
      q = {32'd0, nm} << 16;
      q = q / {32'd0, dm};
      ovf = (q[97:32] != 0);
      if (nneg != dneg) begin
        if (ovf || q[31:0] > 32'h8000_0000) return -longint'(64'h8000_0000);
        return -longint'({32'd0, q[31:0]});
      end
      if (ovf || q[31]) return longint'(64'h7FFF_FFFF);
      return longint'({32'd0, q[31:0]});
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void note_sprite(logic signed [31:0] sx_in, logic signed [31:0] sy_in,
                              logic lift, logic half);
      logic signed [33:0] rx, ry;
      logic signed [66:0] dd, nx, ny;
      logic [65:0] dm, xm, ym;
      longint tx, ty, sx, h, w, z;
      proj_t e;
      e = '{default: 0};
      rx = sx_in - px;
      ry = sy_in - py;
      dd = plx * dy - ply * dx;
      if (dd == 0) begin
        e.inv = 1;
        pending.push_back(e);
        return;
      end
      nx = dy * rx - dx * ry;
      ny = plx * ry - ply * rx;
      dm = dd < 0 ? 66'(-dd) : 66'(dd);
      xm = nx < 0 ? 66'(-nx) : 66'(nx);
      ym = ny < 0 ? 66'(-ny) : 66'(ny);
      tx = q16_ratio(nx < 0, xm, dd < 0, dm);
      ty = q16_ratio(ny < 0, ym, dd < 0, dm);
      if (ty == 0) begin
        e.inv = 1;
        pending.push_back(e);
        return;
      end
      sx = (HALF_W * (ty + tx)) / ty;
      h = (longint'(ssp_pkg::SCREEN_H_DEF) * 65536) / ty;
      if (h < 0) h = -h;
      w = h;
      if (half) h = h / 2;
      z = lift ? ssp_pkg::LIFT_ROWS : 0;
      e.depth  = ty[31:0];
      e.center = 16'(clip(sx, -32768, 32767));
      e.height = 16'(clip(h, 0, 65535));
      e.y0 = 9'(clip(HALF_H + z - h / 2, 0, ssp_pkg::SCREEN_H_DEF - 1));
      e.y1 = 9'(clip(HALF_H + z + h / 2, 0, ssp_pkg::SCREEN_H_DEF - 1));
      e.x0 = 10'(clip(sx - w / 2, 0, ssp_pkg::SCREEN_W_DEF - 1));
      e.x1 = 10'(clip(sx + w / 2, 0, ssp_pkg::SCREEN_W_DEF - 1));
      pending.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(proj_t a);
      proj_t e;
      if (pending.size() == 0) begin
        report("result with no sprite outstanding", 1, 0);
        return;
      end
      e = pending.pop_front();
      if (a.depth !== e.depth) report("depth", a.depth, e.depth);
      if (a.center !== e.center) report("screen_center_x", a.center, e.center);
      if (a.height !== e.height) report("proj_height", a.height, e.height);
      if (a.y0 !== e.y0) report("top_row", a.y0, e.y0);
      if (a.y1 !== e.y1) report("bottom_row", a.y1, e.y1);
      if (a.x0 !== e.x0) report("draw_start_x", a.x0, e.x0);
      if (a.x1 !== e.x1) report("draw_end_x", a.x1, e.x1);
      if (a.inv !== e.inv) report("depth_invalid", a.inv, e.inv);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic start = 0, lift_flag = 0, half_flag = 0, cfg_valid = 0;
  logic signed [31:0] sprite_x = 0, sprite_y = 0;
  logic [ssp_pkg::CFG_IDX_W-1:0] cfg_index = ssp_pkg::REG_PLAYER_X;
  logic [31:0] cfg_data = 0;
  logic busy, cfg_ready, done, depth_invalid;
  logic signed [31:0] depth;
  logic signed [15:0] screen_center_x;
  logic [15:0] proj_height;
  logic [8:0] top_row, bottom_row;
  logic [9:0] draw_start_x, draw_end_x;

  proj_scoreboard sb = new();
  int cycles = 0;
  bit use_gaps;

  sprite_screen_projection dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("[sprite_screen_projection] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result('{depth, screen_center_x, proj_height, top_row,
                        bottom_row, draw_start_x, draw_end_x, depth_invalid});
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (!use_gaps || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_sprite(logic [31:0] x, logic [31:0] y, logic lift, logic half);
    int gap;
    start <= 1;
    sprite_x <= x;
    sprite_y <= y;
    lift_flag <= lift;
    half_flag <= half;
    do @(posedge clk); while (busy);
    sb.note_sprite(x, y, lift, half);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold until the register is taken; the caller drops cfg_valid
  task automatic write_reg(ssp_pkg::reg_idx_t idx, logic [31:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic load_camera(logic [31:0] p_x, p_y, d_x, d_y, pl_x, pl_y);
    drain();
    write_reg(ssp_pkg::REG_PLAYER_X, p_x);
    write_reg(ssp_pkg::REG_PLAYER_Y, p_y);
    write_reg(ssp_pkg::REG_DIR_X, d_x);
    write_reg(ssp_pkg::REG_DIR_Y, d_y);
    write_reg(ssp_pkg::REG_PLANE_X, pl_x);
    write_reg(ssp_pkg::REG_PLANE_Y, pl_y);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] near_val(logic [31:0] c, int span);
    return c + $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic random_sprites(int n);
    logic [31:0] x, y;
    repeat (n) begin
      if ($urandom_range(0, 4) != 0) begin
        x = near_val(sb.px, 1 << 20);
        y = near_val(sb.py, 1 << 20);
      end else begin
        x = $urandom();
        y = $urandom();
      end
      send_sprite(x, y, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    use_gaps = 0;
    // directed, default camera: sprite on the player gives zero depth
    send_sprite(0, 0, 0, 0);
    send_sprite(32'h0002_0000, 0, 0, 0);
    send_sprite(32'h0002_0000, 32'h0000_8000, 1, 0);
    send_sprite(32'h0002_0000, 32'hFFFF_8000, 0, 1);
    send_sprite(32'h0003_0000, 32'h0005_0000, 1, 1);
    send_sprite(32'h0003_0000, 32'hFFF0_0000, 0, 0);
    send_sprite(32'h0000_0001, 0, 0, 0);
    send_sprite(32'hFFFF_FFFF, 0, 1, 1);
    send_sprite(32'hFFFE_0000, 32'h0001_0000, 0, 0);
    send_sprite(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0);
    send_sprite(32'h8000_0000, 32'h8000_0000, 0, 1);
    send_sprite(32'h7FFF_FFFF, 32'h8000_0000, 1, 1);
    send_sprite(32'h0000_4000, 0, 0, 1);
    send_sprite(32'h0001_0000, 32'h0000_0100, 0, 0);
    use_gaps = 1;
    // extreme values in every register for the first camera, all but dir_y for the second
    load_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF);
    random_sprites(60);
    load_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                32'h8000_0000, 32'h8000_0000);
    random_sprites(60);
    // zero determinant
    load_camera($urandom(), $urandom(), $urandom(), $urandom(), 0, 0);
    random_sprites(30);
    for (int ph = 0; ph < 9; ph++) begin
      use_gaps = (ph % 3 != 2);
      if (ph == 8)
        load_camera(0, 0, 32'h0001_0000, 0, 0, 32'h0000_A8F6);
      else
        load_camera(near_val(0, 1 << 22), near_val(0, 1 << 22), near_val(0, 1 << 16),
                    near_val(0, 1 << 16), near_val(0, 1 << 16), near_val(0, 1 << 16));
      random_sprites(120);
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[sprite_screen_projection] OK");
    else
      $display("[sprite_screen_projection] ERROR");
    $finish;
  end
endmodule
